FILE: rtl/brbs_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring buffer with search: shared definitions
// Field widths, operation codes, request and response types, and the
// sequencer state type. The core uses them all; its checker uses the port types.
// ----------------------------------------------------------------------------
package brbs_pkg;

	localparam int OP_W    = 3;
	localparam int DATA_W  = 64;
	localparam int LEN_W   = 7;
	localparam int POS_W   = 10;
	localparam int BYTE_W  = 8;
	localparam int FOUND_W = 11;
	localparam int LEVEL_W = 11;

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ  = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
	localparam logic [OP_W-1:0] OP_FILL  = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

	localparam logic [LEN_W-1:0] WR_MAX_LEN = 7'd8;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [DATA_W-1:0] data_bytes;
		logic [LEN_W-1:0]  length;
		logic              consume;
		logic [POS_W-1:0]  position;
		logic [BYTE_W-1:0] pattern_byte;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  byte_out;
		logic               success;
		logic [FOUND_W-1:0] found_at;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ_ADDR,
		ST_READ_DATA,
		ST_FIND_ADDR,
		ST_FIND_CMP,
		ST_REDUCE,
		ST_FILL,
		ST_RESULT
	} state_t;

endpackage

FILE: rtl/byte_ring_buffer_with_search_core.sv
// ----------------------------------------------------------------------------
// Byte ring buffer with search
// Clear, refusals, unknown codes and empty fills go straight to the response;
// write stores its bytes in turn; peek and read take an address and a data step
// per byte; find compares held bytes from the head to a match or the end; fill
// brings the start below DEPTH, then writes; the single-port store sets the steps.
// One request is in work at a time and the next waits until the last response is
// accepted. Reset clears pointers and count at once; store contents stay undefined.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_search_core
	import brbs_pkg::*;
#(
	parameter int DEPTH    = 1024,
	parameter int MAX_READ = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_stall,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_stall
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > POS_W) ? CW : POS_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_S  = (CW+1)'(DEPTH);
	localparam logic [EW-1:0] DEPTH_E  = EW'(DEPTH);
	localparam logic [EW-1:0] MAXRD_E  = EW'(MAX_READ);

	logic [BYTE_W-1:0] mem [DEPTH];

	state_t            state_q, state_d;
	logic [AW-1:0]     head_q, tail_q, addr_q, addr_next, wrap_idx;
	logic [CW-1:0]     held_q, idx_q, free_cnt;
	logic [LEN_W-1:0]  cnt_q;
	logic [DATA_W-1:0] data_q;
	logic [BYTE_W-1:0] pat_q, rd_data_q, mem_wdata;
	logic [EW-1:0]     red_q;
	rsp_t              rsp_q, rsp_d;
	logic              load_rsp, mem_we, mem_re;
	logic              wr_ok, rd_ok, pk_ok;
	logic [POS_W-1:0]  add_opnd;
	logic [CW:0]       wrap_sum, found_sum;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = (state_q == ST_RESULT);
	assign rsp       = rsp_q;

	assign free_cnt = DEPTH_C - held_q;
	assign wr_ok = (req.length != '0) && (req.length <= WR_MAX_LEN)
		&& (EW'(req.length) <= EW'(free_cnt));
	assign rd_ok = (req.length != '0) && (EW'(req.length) <= MAXRD_E)
		&& (EW'(req.length) <= EW'(held_q));
	assign pk_ok = (EW'(req.position) < EW'(held_q));

	// The offset is no greater than the held count whenever the wrapped index is used.
	assign add_opnd  = (req.operation == OP_PEEK) ? req.position : POS_W'(req.length);
	assign wrap_sum  = (CW+1)'(head_q) + (CW+1)'(add_opnd);
	assign wrap_idx  = (wrap_sum >= DEPTH_S) ? AW'(wrap_sum - DEPTH_S) : AW'(wrap_sum);
	assign found_sum = (CW+1)'(head_q) + (CW+1)'(idx_q);
	assign addr_next = (addr_q == LAST_IDX) ? '0 : addr_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		load_rsp  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = data_q[BYTE_W-1:0];
		rsp_d     = '0;
		rsp_d.last  = 1'b1;
		rsp_d.level = LEVEL_W'(held_q);
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req.operation)
						OP_WRITE: begin
							if (wr_ok) begin
								state_d = ST_WRITE;
							end else begin
								load_rsp = 1'b1;
							end
						end
						OP_READ: begin
							if (rd_ok) begin
								state_d = ST_READ_ADDR;
							end else begin
								load_rsp = 1'b1;
							end
						end
						OP_PEEK: begin
							if (pk_ok) begin
								state_d = ST_READ_ADDR;
							end else begin
								load_rsp = 1'b1;
							end
						end
						OP_FIND: begin
							state_d = ST_FIND_ADDR;
						end
						OP_FILL: begin
							if (req.length == '0) begin
								load_rsp      = 1'b1;
								rsp_d.success = 1'b1;
							end else begin
								state_d = ST_REDUCE;
							end
						end
						OP_CLEAR: begin
							load_rsp      = 1'b1;
							rsp_d.success = 1'b1;
							rsp_d.level   = '0;
						end
						default: begin
							load_rsp = 1'b1;
						end
					endcase
				end
			end
			ST_WRITE: begin
				mem_we = 1'b1;
				if (cnt_q == LEN_W'(1)) begin
					load_rsp      = 1'b1;
					rsp_d.success = 1'b1;
				end
			end
			ST_READ_ADDR: begin
				mem_re  = 1'b1;
				state_d = ST_READ_DATA;
			end
			ST_READ_DATA: begin
				load_rsp       = 1'b1;
				rsp_d.byte_out = rd_data_q;
				rsp_d.success  = 1'b1;
				rsp_d.last     = (cnt_q == LEN_W'(1));
			end
			ST_FIND_ADDR: begin
				if (idx_q == held_q) begin
					load_rsp = 1'b1;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_FIND_CMP;
				end
			end
			ST_FIND_CMP: begin
				if (rd_data_q == pat_q) begin
					load_rsp       = 1'b1;
					rsp_d.success  = 1'b1;
					rsp_d.found_at = FOUND_W'(found_sum);
				end else begin
					state_d = ST_FIND_ADDR;
				end
			end
			ST_REDUCE: begin
				if (red_q < DEPTH_E) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = pat_q;
				if (cnt_q == LEN_W'(1)) begin
					load_rsp      = 1'b1;
					rsp_d.success = 1'b1;
				end
			end
			ST_RESULT: begin
				if (!rsp_stall) begin
					state_d = rsp_q.last ? ST_IDLE : ST_READ_ADDR;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (load_rsp) begin
			state_d = ST_RESULT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			held_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cnt_q <= req.length;
						idx_q <= '0;
						case (req.operation)
							OP_WRITE: begin
								if (wr_ok) begin
									held_q <= held_q + CW'(req.length);
								end
							end
							OP_READ: begin
								if (rd_ok && req.consume) begin
									head_q <= wrap_idx;
									held_q <= held_q - CW'(req.length);
								end
							end
							OP_PEEK: begin
								cnt_q <= LEN_W'(1);
							end
							OP_CLEAR: begin
								head_q <= '0;
								tail_q <= '0;
								held_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WRITE: begin
					cnt_q <= cnt_q - LEN_W'(1);
					if (cnt_q == LEN_W'(1)) begin
						tail_q <= addr_next;
					end
				end
				ST_READ_DATA, ST_FILL: begin
					cnt_q <= cnt_q - LEN_W'(1);
				end
				ST_FIND_CMP: begin
					idx_q <= idx_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
		case (state_q)
			ST_IDLE: begin
				data_q <= req.data_bytes;
				pat_q  <= req.pattern_byte;
				red_q  <= EW'(req.position);
				case (req.operation)
					OP_WRITE: addr_q <= tail_q;
					OP_PEEK:  addr_q <= wrap_idx;
					default:  addr_q <= head_q;
				endcase
			end
			ST_WRITE: begin
				data_q <= data_q >> BYTE_W;
				addr_q <= addr_next;
			end
			ST_READ_DATA, ST_FIND_CMP, ST_FILL: begin
				addr_q <= addr_next;
			end
			ST_REDUCE: begin
				if (red_q >= DEPTH_E) begin
					red_q <= red_q - DEPTH_E;
				end else begin
					addr_q <= AW'(red_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[addr_q];
		end
	end

endmodule

FILE: rtl/brbs_checker.sv
// ----------------------------------------------------------------------------
// Byte ring buffer with search: port checker
// Watches the ports of the core over time and flags responses or handshakes
// that the sequencer can never produce.
// ----------------------------------------------------------------------------
module brbs_checker
	import brbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input req_t req,
	input logic req_valid,
	input logic req_stall,
	input rsp_t rsp,
	input logic rsp_valid,
	input logic rsp_stall
);

	// A pending response always blocks the next request.
	a_busy_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request channel open while a response is pending");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request channel open right after a request");

	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.success) |-> (rsp.last && rsp.byte_out == '0
			&& rsp.found_at == '0))
		else $error("refused request gave a non-final or nonzero response");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

endmodule

bind byte_ring_buffer_with_search_core brbs_checker u_brbs_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer with search testbench
// Sends directed and random requests through the valid/stall request port.
// A scoreboard keeps its own copy of the ring, predicts every response, and
// checks the responses in order. Both sides idle at random.
// ----------------------------------------------------------------------------
import brbs_pkg::*;

class ring_scoreboard;
	localparam int RING_DEPTH = 1024;
	localparam int READ_MAX   = 64;

	logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
	int unsigned head_ptr;
	int unsigned tail_ptr;
	int unsigned held;
	rsp_t expected_q [$];
	int errors;

	function new();
		head_ptr = 0;
		tail_ptr = 0;
		held = 0;
		errors = 0;
	endfunction

	function void push_rsp(logic [BYTE_W-1:0] b, logic ok, int unsigned at, logic lst);
		rsp_t r;
		r.byte_out = b;
		r.success  = ok;
		r.found_at = at[FOUND_W-1:0];
		r.level    = held[LEVEL_W-1:0];
		r.last     = lst;
		expected_q.push_back(r);
	endfunction

	function void note(req_t r);
		int unsigned len;
		int unsigned start;
		int unsigned i;
		bit hit;
		len = r.length;
		case (r.operation)
		OP_WRITE: begin
			if (len < 1 || len > WR_MAX_LEN || len > RING_DEPTH - held) begin
				push_rsp('0, 1'b0, 0, 1'b1);
			end else begin
				for (i = 0; i < len; i++) begin
					ring_mem[tail_ptr] = r.data_bytes[8*i +: 8];
					tail_ptr = (tail_ptr + 1) % RING_DEPTH;
				end
				held += len;
				push_rsp('0, 1'b1, 0, 1'b1);
			end
		end
		OP_READ: begin
			if (len < 1 || len > READ_MAX || len > held) begin
				push_rsp('0, 1'b0, 0, 1'b1);
			end else begin
				start = head_ptr;
				if (r.consume) begin
					head_ptr = (head_ptr + len) % RING_DEPTH;
					held -= len;
				end
				for (i = 0; i < len; i++) begin
					push_rsp(ring_mem[(start + i) % RING_DEPTH], 1'b1, 0, i + 1 == len);
				end
			end
		end
		OP_PEEK: begin
			if (r.position < held) begin
				push_rsp(ring_mem[(head_ptr + r.position) % RING_DEPTH], 1'b1, 0, 1'b1);
			end else begin
				push_rsp('0, 1'b0, 0, 1'b1);
			end
		end
		OP_FIND: begin
			hit = 1'b0;
			for (i = 0; i < held && !hit; i++) begin
				if (ring_mem[(head_ptr + i) % RING_DEPTH] == r.pattern_byte) begin
					hit = 1'b1;
					push_rsp('0, 1'b1, head_ptr + i, 1'b1);
				end
			end
			if (!hit) begin
				push_rsp('0, 1'b0, 0, 1'b1);
			end
		end
		OP_FILL: begin
			for (i = 0; i < len; i++) begin
				ring_mem[(r.position + i) % RING_DEPTH] = r.pattern_byte;
			end
			push_rsp('0, 1'b1, 0, 1'b1);
		end
		OP_CLEAR: begin
			head_ptr = 0;
			tail_ptr = 0;
			held = 0;
			push_rsp('0, 1'b1, 0, 1'b1);
		end
		default: begin
			push_rsp('0, 1'b0, 0, 1'b1);
		end
		endcase
	endfunction

	function void flag(string what, rsp_t got, rsp_t want);
		errors++;
		if (errors <= 10) begin
			$display("MISMATCH %s: got byte=%h ok=%b at=%0d level=%0d last=%b",
				what, got.byte_out, got.success, got.found_at, got.level, got.last);
			$display("  expected byte=%h ok=%b at=%0d level=%0d last=%b",
				want.byte_out, want.success, want.found_at, want.level, want.last);
		end
	endfunction

	function void check(rsp_t got);
		rsp_t want;
		if (expected_q.size() == 0) begin
			flag("response with no request outstanding", got, '0);
		end else begin
			want = expected_q.pop_front();
			if (got.byte_out !== want.byte_out || got.success !== want.success ||
				got.found_at !== want.found_at || got.level !== want.level ||
				got.last !== want.last) begin
				flag("response", got, want);
			end
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb;
	localparam int SIM_LIMIT   = 4_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 2500;
	localparam int RING_DEPTH  = 1024;
	localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	req_t req = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	rsp_t rsp;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int cycle_count = 0;
	ring_scoreboard sb = new();

	byte_ring_buffer_with_search_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp(rsp),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check(rsp);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (cycle_count < SIM_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	function automatic req_t make_req(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
		int len, bit cons, int pos, int pat);
		req_t r;
		r.operation    = op;
		r.data_bytes   = data;
		r.length       = len[LEN_W-1:0];
		r.consume      = cons;
		r.position     = pos[POS_W-1:0];
		r.pattern_byte = pat[BYTE_W-1:0];
		return r;
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int pick;
		int unsigned cnt;
		int unsigned cap;
		cnt = sb.held;
		r.data_bytes   = {$urandom, $urandom};
		r.consume      = 1'($urandom_range(0, 1));
		r.position     = POS_W'($urandom_range(0, 1023));
		r.pattern_byte = BYTE_W'($urandom_range(0, 255));
		r.length       = LEN_W'($urandom_range(0, 127));
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			r.operation = OP_WRITE;
			if ($urandom_range(0, 9) != 0) begin
				r.length = LEN_W'($urandom_range(1, 8));
			end
		end else if (pick < 62) begin
			r.operation = OP_READ;
			if (cnt > 0 && $urandom_range(0, 7) != 0) begin
				cap = ($urandom_range(0, 3) == 0) ? 64 : 12;
				if (cap > cnt) begin
					cap = cnt;
				end
				r.length = LEN_W'($urandom_range(1, cap));
			end
		end else if (pick < 74) begin
			r.operation = OP_PEEK;
			if (cnt > 0 && $urandom_range(0, 4) != 0) begin
				r.position = POS_W'($urandom_range(0, cnt - 1));
			end
		end else if (pick < 84) begin
			r.operation = OP_FIND;
			if (cnt > 0 && $urandom_range(0, 2) != 0) begin
				r.pattern_byte =
					sb.ring_mem[(sb.head_ptr + $urandom_range(0, cnt - 1)) % RING_DEPTH];
			end
		end else if (pick < 94) begin
			r.operation = OP_FILL;
			if ($urandom_range(0, 3) != 0) begin
				r.length = LEN_W'($urandom_range(0, 12));
			end
		end else if (pick < 97) begin
			r.operation = OP_CLEAR;
		end else begin
			r.operation = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
		end
		return r;
	endfunction

	task automatic idle_sender(int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic issue(req_t r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note(r);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			idle_sender($urandom_range(1, 12));
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned n;
		int unsigned room;
		int unsigned wlen;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(make_req(OP_WRITE, {DATA_W{1'b1}}, 8, 1'b0, 0, 0));
		issue(make_req(OP_WRITE, '0, 1, 1'b0, 0, 0));
		issue(make_req(OP_WRITE, 64'h0123_4567_89AB_CDEF, 0, 1'b0, 0, 0));
		issue(make_req(OP_WRITE, 64'h0123_4567_89AB_CDEF, 9, 1'b0, 0, 0));
		issue(make_req(OP_WRITE, 64'h5A5A_5A5A_5A5A_5A5A, 127, 1'b1, 1023, 255));
		issue(make_req(OP_PEEK, '0, 0, 1'b0, 0, 0));
		issue(make_req(OP_PEEK, '0, 0, 1'b0, 8, 0));
		issue(make_req(OP_PEEK, '0, 0, 1'b0, 9, 0));
		issue(make_req(OP_PEEK, '0, 0, 1'b0, 1023, 0));
		issue(make_req(OP_READ, '0, 2, 1'b0, 0, 0));
		issue(make_req(OP_READ, '0, 0, 1'b1, 0, 0));
		issue(make_req(OP_READ, '0, 65, 1'b1, 0, 0));
		issue(make_req(OP_READ, '0, 10, 1'b1, 0, 0));
		issue(make_req(OP_FIND, '0, 0, 1'b0, 0, 8'h00));
		issue(make_req(OP_FIND, '0, 0, 1'b0, 0, 8'h3C));
		issue(make_req(OP_READ, '0, 9, 1'b1, 0, 0));
		issue(make_req(OP_READ, '0, 1, 1'b1, 0, 0));
		issue(make_req(OP_FIND, '0, 0, 1'b0, 0, 8'hFF));
		issue(make_req(OP_FILL, '0, 10, 1'b0, 1020, 8'hA5));
		issue(make_req(OP_FILL, '0, 0, 1'b0, 0, 8'h11));
		issue(make_req(OP_FILL, '0, 127, 1'b0, 1023, 8'hFF));
		issue(make_req(OP_CLEAR, '0, 0, 1'b0, 0, 0));
		issue(make_req(OP_UNUSED_A, '0, 1, 1'b1, 0, 0));
		issue(make_req(OP_UNUSED_B, '1, 127, 1'b1, 1023, 255));
		issue(make_req(OP_WRITE, 64'hFEDC_BA98_7654_3210, 8, 1'b0, 0, 0));
		issue(make_req(OP_READ, '0, 8, 1'b1, 0, 0));

		for (n = 0; n < 90; n++) begin
			if (n == 40) begin
				hold_req = 1'b1;
			end
			issue(rand_req());
		end

		wait_drained();

		// Take the ring up to exactly full, then work it at the top of its range.
		while (sb.held < RING_DEPTH) begin
			room = RING_DEPTH - sb.held;
			wlen = 8;
			if (wlen > room) begin
				wlen = room;
			end
			issue(make_req(OP_WRITE, {$urandom, $urandom}, wlen, 1'($urandom_range(0, 1)),
				$urandom_range(0, 1023), $urandom_range(0, 255)));
		end
		issue(make_req(OP_WRITE, {$urandom, $urandom}, 1, 1'b0, 0, 0));
		issue(make_req(OP_PEEK, '0, 0, 1'b0, 1023, 0));
		issue(make_req(OP_FIND, '0, 0, 1'b0, 0,
			sb.ring_mem[(sb.head_ptr + RING_DEPTH - 1) % RING_DEPTH]));
		issue(make_req(OP_READ, '0, 64, 1'b0, 0, 0));
		issue(make_req(OP_READ, '0, 64, 1'b1, 0, 0));
		issue(make_req(OP_WRITE, {$urandom, $urandom}, 8, 1'b0, 0, 0));
		issue(make_req(OP_FIND, '0, 0, 1'b0, 0,
			sb.ring_mem[(sb.head_ptr + sb.held - 1) % RING_DEPTH]));

		for (n = 0; n < 90; n++) begin
			if (n == 60) begin
				quiet = 1'b1;
			end
			issue(rand_req());
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
